FILE: sv/brb_pkg.sv
// ----------------------------------------------------------------------------
// Byte ring buffer package
// Sizes, codes and controller/datapath handshake types for the chunked
// byte ring buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int DEPTH    = 4096;
  localparam int MAX_READ = 64;
  localparam int RESERVE  = 2;

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CMD_W  = 2;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 13;
  localparam int STS_W  = 2;
  localparam int HELD_W = 12;
  localparam int RUN_W  = $clog2(MAX_READ + 1);
  localparam int CALC_W = ((LEN_W > IDX_W + 1) ? LEN_W : IDX_W + 1) + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 0,
    CMD_READ  = 1,
    CMD_PEEK  = 2
  } cmd_e;

  typedef enum logic [STS_W-1:0] {
    STS_DATA     = 0,
    STS_ACCEPTED = 1,
    STS_REJECTED = 2,
    STS_EMPTY    = 3
  } status_e;

  typedef struct packed {
    logic accept;
    logic start_run;
    logic issue_rd;
    logic load_byte;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_valid;
    logic run_req;
    logic pend;
    logic cnt_zero;
  } dp_status_t;

endpackage

FILE: sv/brb_if.sv
// ----------------------------------------------------------------------------
// Byte ring buffer channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface brb_in_if import brb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [BYTE_W-1:0] byte_value;
  logic              first_of_chunk;
  logic [LEN_W-1:0]  length;

  modport source (output valid, command, byte_value, first_of_chunk, length, input ready);
  modport sink (input valid, command, byte_value, first_of_chunk, length, output ready);
endinterface

interface brb_out_if import brb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STS_W-1:0]  status;
  logic [BYTE_W-1:0] out_byte;
  logic              last_of_run;
  logic [HELD_W-1:0] held_count;

  modport source (output valid, status, out_byte, last_of_run, held_count, input ready);
  modport sink (input valid, status, out_byte, last_of_run, held_count, output ready);
endinterface

FILE: sv/brb_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/brb_ctrl.sv
// ----------------------------------------------------------------------------
// Byte ring buffer controller
// Accepts request items and sequences the byte reads of a read or peek run.
// ----------------------------------------------------------------------------
module brb_ctrl import brb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       out_ready_i,
  input  dp_status_t sts_i,
  output logic       in_ready_o,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  state_e state_q, state_d;
  logic   out_free;

  always_comb begin
    out_free   = !sts_i.out_valid || out_ready_i;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    state_d    = state_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o      = out_free;
        cmd_o.accept    = in_valid_i && out_free;
        cmd_o.start_run = cmd_o.accept && sts_i.run_req;
        if (cmd_o.start_run) begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        cmd_o.load_byte = sts_i.pend && out_free;
        cmd_o.issue_rd  = !sts_i.cnt_zero && (!sts_i.pend || cmd_o.load_byte);
        if (cmd_o.load_byte && sts_i.cnt_zero) begin
          state_d = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: sv/brb_dp.sv
// ----------------------------------------------------------------------------
// Byte ring buffer datapath
// Pointers, chunk tracking, read run counters, byte store and result register.
// ----------------------------------------------------------------------------
module brb_dp import brb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_cmd_t         cmd_i,
  output dp_status_t        sts_o,
  input  logic [CMD_W-1:0]  command_i,
  input  logic [BYTE_W-1:0] byte_value_i,
  input  logic              first_of_chunk_i,
  input  logic [LEN_W-1:0]  length_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [STS_W-1:0]  status_o,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              last_of_run_o,
  output logic [HELD_W-1:0] held_count_o
);

  localparam logic [CALC_W-1:0] DepthW   = CALC_W'(DEPTH);
  localparam logic [CALC_W-1:0] ReserveW = CALC_W'(RESERVE);
  localparam logic [CALC_W-1:0] MaxReadW = CALC_W'(MAX_READ);

  logic [IDX_W-1:0]  rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [IDX_W-1:0]  pos_q, pos_d, run_held_q, run_held_d;
  logic              accepting_q, accepting_d;
  logic [LEN_W-1:0]  left_q, left_d;
  logic [RUN_W-1:0]  cnt_q, cnt_d;
  logic              pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  logic [STS_W-1:0]  status_q, status_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic              last_q, last_d;
  logic [HELD_W-1:0] held_q, held_d;

  logic [CALC_W-1:0] rd_w, wr_w, held_w, room_w, free_w, len_w, n_w;
  logic [CALC_W-1:0] rd_sum, rd_wrap, pos_inc, pos_next, wr_inc, wr_next;
  logic              fits, is_rd_cmd;
  logic              we;
  logic [BYTE_W-1:0] rdata;

  always_comb begin
    rd_w     = CALC_W'(rd_ptr_q);
    wr_w     = CALC_W'(wr_ptr_q);
    held_w   = (wr_w >= rd_w) ? wr_w - rd_w : DepthW - rd_w + wr_w;
    room_w   = DepthW - held_w;
    free_w   = (room_w > ReserveW) ? room_w - ReserveW : '0;
    len_w    = CALC_W'(length_i);
    fits     = len_w <= free_w;
    n_w      = len_w;
    if (n_w > held_w) begin
      n_w = held_w;
    end
    if (n_w > MaxReadW) begin
      n_w = MaxReadW;
    end
    rd_sum   = rd_w + n_w;
    rd_wrap  = (rd_sum >= DepthW) ? rd_sum - DepthW : rd_sum;
    pos_inc  = CALC_W'(pos_q) + CALC_W'(1);
    pos_next = (pos_inc >= DepthW) ? '0 : pos_inc;
    wr_inc   = wr_w + CALC_W'(1);
    wr_next  = (wr_inc >= DepthW) ? '0 : wr_inc;
    is_rd_cmd = (command_i == CMD_READ) || (command_i == CMD_PEEK);
  end

  assign sts_o.out_valid = out_valid_q;
  assign sts_o.run_req   = is_rd_cmd && (n_w != '0);
  assign sts_o.pend      = pend_q;
  assign sts_o.cnt_zero  = (cnt_q == '0);

  always_comb begin
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    pos_d       = pos_q;
    run_held_d  = run_held_q;
    accepting_d = accepting_q;
    left_d      = left_q;
    cnt_d       = cnt_q;
    we          = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    byte_d      = byte_q;
    last_d      = last_q;
    held_d      = held_q;

    if (cmd_i.accept) begin
      case (command_i) inside
        CMD_WRITE: begin
          if (first_of_chunk_i) begin
            out_valid_d = 1'b1;
            byte_d      = '0;
            last_d      = 1'b1;
            if (fits) begin
              status_d = STS_ACCEPTED;
              if (length_i != '0) begin
                we          = 1'b1;
                wr_ptr_d    = wr_next[IDX_W-1:0];
                left_d      = length_i - LEN_W'(1);
                accepting_d = (length_i != LEN_W'(1));
                held_d      = HELD_W'(held_w + CALC_W'(1));
              end else begin
                left_d      = '0;
                accepting_d = 1'b0;
                held_d      = HELD_W'(held_w);
              end
            end else begin
              status_d    = STS_REJECTED;
              left_d      = '0;
              accepting_d = 1'b0;
              held_d      = HELD_W'(held_w);
            end
          end else if (accepting_q && (left_q != '0)) begin
            we          = 1'b1;
            wr_ptr_d    = wr_next[IDX_W-1:0];
            left_d      = left_q - LEN_W'(1);
            accepting_d = (left_q != LEN_W'(1));
          end
        end
        CMD_READ, CMD_PEEK: begin
          if (cmd_i.start_run) begin
            pos_d = rd_ptr_q;
            cnt_d = n_w[RUN_W-1:0];
            if (command_i == CMD_READ) begin
              rd_ptr_d   = rd_wrap[IDX_W-1:0];
              run_held_d = IDX_W'(held_w - n_w);
            end else begin
              run_held_d = IDX_W'(held_w);
            end
          end else begin
            out_valid_d = 1'b1;
            status_d    = STS_EMPTY;
            byte_d      = '0;
            last_d      = 1'b1;
            held_d      = HELD_W'(held_w);
          end
        end
        default: ;
      endcase
    end

    if (cmd_i.issue_rd) begin
      pos_d = pos_next[IDX_W-1:0];
      cnt_d = cnt_q - RUN_W'(1);
    end

    if (cmd_i.load_byte) begin
      out_valid_d = 1'b1;
      status_d    = STS_DATA;
      byte_d      = rdata;
      last_d      = (cnt_q == '0);
      held_d      = HELD_W'(run_held_q);
    end

    pend_d = cmd_i.issue_rd || (pend_q && !cmd_i.load_byte);
  end

  brb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wr_ptr_q),
    .wdata_i (byte_value_i),
    .re_i    (cmd_i.issue_rd),
    .raddr_i (pos_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      accepting_q <= 1'b0;
      left_q      <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      accepting_q <= accepting_d;
      left_q      <= left_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    run_held_q <= run_held_d;
    status_q   <= status_d;
    byte_q     <= byte_d;
    last_q     <= last_d;
    held_q     <= held_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign out_byte_o    = byte_q;
  assign last_of_run_o = last_q;
  assign held_count_o  = held_q;

endmodule

FILE: sv/byte_ring_buffer_chunked.sv
// ----------------------------------------------------------------------------
// Chunked byte ring buffer
// A 4096-byte circular store with all-or-nothing chunk writes and read and
// peek requests of up to 64 bytes.
//
// Requests enter on in_i and results leave on out_o, both valid/ready
// channels; a transaction completes when valid and ready are both high.
// The first byte of a chunk gives one result (accepted or rejected) in the
// result register in the next cycle; later bytes of a chunk give none. A read
// or peek of n bytes registers the request, then reads the store one byte
// per cycle, while the receiver takes results, through its single read port;
// each byte passes the store's read register and then the result register,
// and the next request is taken only after the last byte of the run is loaded.
// An empty or zero-length read gives a single result in the next cycle.
// A new request is taken only when the result register is empty or is being
// drained in the same cycle; while the receiver stalls, the block holds its
// current result and takes nothing. Reset empties the buffer and closes any
// open chunk; the store contents are not cleared.
// ----------------------------------------------------------------------------
module byte_ring_buffer_chunked import brb_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  brb_in_if.sink      in_i,
  brb_out_if.source   out_o
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;
  logic       in_ready;

  brb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .in_ready_o  (in_ready),
    .cmd_o       (cmd)
  );

  brb_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .command_i        (in_i.command),
    .byte_value_i     (in_i.byte_value),
    .first_of_chunk_i (in_i.first_of_chunk),
    .length_i         (in_i.length),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .status_o         (out_o.status),
    .out_byte_o       (out_o.out_byte),
    .last_of_run_o    (out_o.last_of_run),
    .held_count_o     (out_o.held_count)
  );

  assign in_i.ready = in_ready;

endmodule

FILE: tb/tb_byte_ring_buffer_chunked.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Chunked byte ring buffer testbench
// Drives write chunks, reads and peeks into the ring buffer with random gaps
// on the request side and random stalls on the result side. A scoreboard
// keeps its own copy of the store and pointers, predicts every result of each
// accepted request, and checks the results in order. The run announces
// chunks of exactly the free space and of one byte more, so both sides of
// the accept and reject boundary are reached.
// ----------------------------------------------------------------------------
module tb_byte_ring_buffer_chunked;
  import brb_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 420;
  localparam int unsigned MAX_GAP      = 24;
  localparam int unsigned MAX_STALL    = 40;
  localparam int unsigned TAIL_CYCLES  = 20;
  localparam int unsigned MAX_CHUNK_ITEMS = 48;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  typedef struct {
    logic [STS_W-1:0]  status;
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
    logic [HELD_W-1:0] held_count;
  } ring_result_t;

  class ring_scoreboard;
    logic [BYTE_W-1:0] store_mem [DEPTH];
    logic [IDX_W-1:0]  rd_ptr;
    logic [IDX_W-1:0]  wr_ptr;
    bit                chunk_open;
    int unsigned       chunk_left;
    ring_result_t      expected_results [$];
    int unsigned       error_count;

    function new();
      rd_ptr      = '0;
      wr_ptr      = '0;
      chunk_open  = 1'b0;
      chunk_left  = 0;
      error_count = 0;
    endfunction

    function int unsigned held_bytes();
      logic [IDX_W-1:0] diff;
      diff = wr_ptr - rd_ptr;
      return 32'(diff);
    endfunction

    function void push_byte(logic [BYTE_W-1:0] value);
      store_mem[wr_ptr] = value;
      wr_ptr++;
      chunk_left--;
      if (chunk_left == 0) chunk_open = 1'b0;
    endfunction

    function void expect_result(logic [STS_W-1:0] status, logic [BYTE_W-1:0] value,
                                logic last, int unsigned held);
      ring_result_t res;
      res.status      = status;
      res.out_byte    = value;
      res.last_of_run = last;
      res.held_count  = held[HELD_W-1:0];
      expected_results.push_back(res);
    endfunction

    // Returns the number of results the request causes.
    function int note_request(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] value,
                              logic first, logic [LEN_W-1:0] len);
      int unsigned held;
      int unsigned room;
      int unsigned free_space;
      int unsigned n;
      logic [IDX_W-1:0] pos;
      held = held_bytes();
      case (cmd)
        CMD_WRITE: begin
          if (!first) begin
            if (chunk_open && chunk_left > 0) push_byte(value);
            return 0;
          end
          room = DEPTH - held;
          free_space = (room > RESERVE) ? room - RESERVE : 0;
          if (len <= free_space) begin
            chunk_open = 1'b1;
            chunk_left = 32'(len);
            if (chunk_left > 0) push_byte(value);
            else chunk_open = 1'b0;
            expect_result(STS_ACCEPTED, '0, 1'b1, held_bytes());
          end else begin
            chunk_open = 1'b0;
            chunk_left = 0;
            expect_result(STS_REJECTED, '0, 1'b1, held);
          end
          return 1;
        end
        CMD_READ, CMD_PEEK: begin
          n = 32'(len);
          if (n > held) n = held;
          if (n > MAX_READ) n = MAX_READ;
          if (n == 0) begin
            expect_result(STS_EMPTY, '0, 1'b1, held);
            return 1;
          end
          pos = rd_ptr;
          if (cmd == CMD_READ) held = held - n;
          for (int unsigned k = 0; k < n; k++) begin
            expect_result(STS_DATA, store_mem[pos], k + 1 == n, held);
            pos++;
          end
          if (cmd == CMD_READ) rd_ptr = pos;
          return n;
        end
        default: return 0;
      endcase
    endfunction

    function void check_result(ring_result_t got);
      ring_result_t exp;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: status %0d byte %0h last %0b held %0d",
                 $time, got.status, got.out_byte, got.last_of_run, got.held_count);
        error_count++;
        return;
      end
      exp = expected_results.pop_front();
      if (got.status !== exp.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, exp.status, got.status);
        error_count++;
      end
      if (got.out_byte !== exp.out_byte) begin
        $display("%0t: out_byte mismatch: expected %0h, actual %0h",
                 $time, exp.out_byte, got.out_byte);
        error_count++;
      end
      if (got.last_of_run !== exp.last_of_run) begin
        $display("%0t: last_of_run mismatch: expected %0b, actual %0b",
                 $time, exp.last_of_run, got.last_of_run);
        error_count++;
      end
      if (got.held_count !== exp.held_count) begin
        $display("%0t: held_count mismatch: expected %0d, actual %0d",
                 $time, exp.held_count, got.held_count);
        error_count++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  brb_in_if  in_bus ();
  brb_out_if out_bus ();

  byte_ring_buffer_chunked u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  ring_scoreboard sb;
  int unsigned    cycle_count  = 0;
  longint         cycle_budget = 0;
  int unsigned    send_count   = 0;
  int unsigned    send_idle_pct = 0;
  int unsigned    stall_pct    = 0;
  int unsigned    stall_left   = 0;

  initial begin
    clk_i = 1'b0;
  end

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 4 * cycle_budget + 20000) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    ring_result_t got;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got.status      = out_bus.status;
      got.out_byte    = out_bus.out_byte;
      got.last_of_run = out_bus.last_of_run;
      got.held_count  = out_bus.held_count;
      sb.check_result(got);
    end
    if (cycle_count % 256 == 0) begin
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 15;
        default: stall_pct = 45;
      endcase
    end
    if (stall_left != 0) begin
      stall_left--;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 3)
                                              : $urandom_range(8, MAX_STALL);
    end
    out_bus.ready <= (stall_left == 0);
  end

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) >= send_idle_pct) return 0;
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(8, MAX_GAP);
  endfunction

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] value,
                              input logic first, input logic [LEN_W-1:0] len);
    int unsigned gap;
    int n;
    gap = pick_gap();
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid          <= 1'b1;
    in_bus.command        <= cmd;
    in_bus.byte_value     <= value;
    in_bus.first_of_chunk <= first;
    in_bus.length         <= len;
    do @(posedge clk_i); while (!in_bus.ready);
    n = sb.note_request(cmd, value, first, len);
    cycle_budget += gap + 4 + n * (MAX_STALL + 2);
    send_count++;
    if (send_count % 64 == 0) begin
      case ($urandom_range(0, 2))
        0: send_idle_pct = 0;
        1: send_idle_pct = 15;
        default: send_idle_pct = 40;
      endcase
    end
  endtask

  // Sends a first byte announcing len, followed by count - 1 further bytes.
  task automatic send_chunk(input logic [LEN_W-1:0] len, input int unsigned count);
    send_request(CMD_WRITE, BYTE_W'($urandom_range(0, 255)), 1'b1, len);
    for (int unsigned k = 1; k < count; k++) begin
      send_request(CMD_WRITE, BYTE_W'($urandom_range(0, 255)),
                   $urandom_range(0, 7) == 0 ? 1'b0 : 1'b0,
                   LEN_W'($urandom_range(0, 8191)));
    end
  endtask

  task automatic send_read(input logic [LEN_W-1:0] len);
    send_request($urandom_range(0, 2) != 0 ? CMD_READ : CMD_PEEK,
                 BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), len);
  endtask

  task automatic wait_drained();
    while (sb.expected_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned start_count;
    int unsigned free_space;
    int unsigned len;
    int unsigned count;
    int unsigned pick;

    sb = new();
    rst_ni                = 1'b0;
    in_bus.valid          = 1'b0;
    in_bus.command        = CMD_WRITE;
    in_bus.byte_value     = '0;
    in_bus.first_of_chunk = 1'b0;
    in_bus.length         = '0;
    out_bus.ready         = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty reads, stray bytes and a zero-length chunk.
    send_request(CMD_READ, 8'h00, 1'b0, 13'd5);
    send_request(CMD_PEEK, 8'hFF, 1'b1, 13'd0);
    send_request(CMD_WRITE, 8'hAA, 1'b0, 13'd0);
    send_request(CMD_WRITE, 8'h00, 1'b1, 13'd0);
    send_request(CMD_WRITE, 8'h11, 1'b0, 13'd3);
    // A four-byte chunk with one byte too many.
    send_request(CMD_WRITE, 8'hFF, 1'b1, 13'd4);
    send_request(CMD_WRITE, 8'h00, 1'b0, LEN_MAX);
    send_request(CMD_WRITE, 8'h5A, 1'b0, 13'd0);
    send_request(CMD_WRITE, 8'hA5, 1'b0, 13'd0);
    send_request(CMD_WRITE, 8'h77, 1'b0, 13'd0);
    send_request(CMD_PEEK, 8'h00, 1'b0, 13'd2);
    send_request(CMD_READ, 8'hFF, 1'b1, 13'd0);
    // An abandoned chunk followed by a complete one.
    send_request(CMD_WRITE, 8'h01, 1'b1, 13'd6);
    send_request(CMD_WRITE, 8'h02, 1'b0, 13'd0);
    send_request(CMD_WRITE, 8'h03, 1'b1, 13'd3);
    send_request(CMD_WRITE, 8'h04, 1'b0, 13'd0);
    send_request(CMD_WRITE, 8'h05, 1'b0, 13'd0);
    send_request(CMD_UNUSED, 8'hFF, 1'b1, LEN_MAX);
    // A rejected chunk whose bytes are dropped.
    send_request(CMD_WRITE, 8'hC3, 1'b1, LEN_MAX);
    send_request(CMD_WRITE, 8'h3C, 1'b0, 13'd0);
    send_request(CMD_WRITE, 8'h96, 1'b0, 13'd0);
    send_request(CMD_READ, 8'h00, 1'b0, LEN_MAX);
    send_request(CMD_PEEK, 8'h00, 1'b0, 13'd1);

    in_bus.valid <= 1'b0;
    wait_drained();

    // Announce chunks of one byte more than the free space and of exactly
    // the free space, on an empty and on a partly filled buffer.
    free_space = DEPTH - sb.held_bytes() - RESERVE;
    send_request(CMD_WRITE, 8'h41, 1'b1, LEN_W'(free_space + 1));
    send_chunk(LEN_W'(free_space), 3);
    free_space = DEPTH - sb.held_bytes() - RESERVE;
    send_request(CMD_WRITE, 8'h42, 1'b1, LEN_W'(free_space + 1));
    send_request(CMD_WRITE, 8'h43, 1'b1, LEN_W'(free_space));
    send_request(CMD_WRITE, 8'h44, 1'b1, 13'd0);
    send_request(CMD_PEEK, 8'h00, 1'b0, 13'd64);
    while (sb.held_bytes() != 0) begin
      case ($urandom_range(0, 2))
        0: send_read(13'd64);
        1: send_read(LEN_MAX);
        default: send_read(LEN_W'($urandom_range(1, 64)));
      endcase
    end

    start_count = send_count;
    while (send_count - start_count < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (sb.held_bytes() > 600 && pick < 55) pick = pick + 30;
      if (pick < 55) begin
        case ($urandom_range(0, 9))
          0:    len = 0;
          1:    len = $urandom_range(25, 200);
          2:    len = $urandom_range(0, 8191);
          default: len = $urandom_range(1, 24);
        endcase
        if (len > DEPTH - sb.held_bytes() - RESERVE) begin
          count = $urandom_range(1, 4);
        end else begin
          case ($urandom_range(0, 9))
            0:    count = (len > 1) ? $urandom_range(1, len - 1) : 1;
            1:    count = len + $urandom_range(1, 3);
            default: count = (len == 0) ? 1 : len;
          endcase
        end
        if (count > MAX_CHUNK_ITEMS) count = $urandom_range(2, 8);
        send_chunk(LEN_W'(len), count);
      end else if (pick < 88) begin
        case ($urandom_range(0, 19))
          0, 1:    len = 0;
          2, 3, 4: len = $urandom_range(65, 8191);
          5:       len = sb.held_bytes();
          default: len = $urandom_range(1, 64);
        endcase
        send_read(LEN_W'(len));
      end else if (pick < 95) begin
        send_request(CMD_WRITE, BYTE_W'($urandom_range(0, 255)), 1'b0,
                     LEN_W'($urandom_range(0, 8191)));
      end else begin
        send_request(CMD_UNUSED, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     LEN_W'($urandom_range(0, 8191)));
      end
    end

    in_bus.valid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.error_count == 0 && sb.expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
